>>> design/apct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apct_pkg
// Shared types and codes for the AABB pair contact tracker: controller
// states, contact event codes and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package apct_pkg;

    localparam int EVENT_W   = 3;
    localparam int CFG_DW    = 64;
    localparam int CFG_AW    = 4;

    // Register map: layer_enable at byte address 0
    localparam logic [CFG_AW-1:0] ADDR_LAYER_ENABLE = 4'h0;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE    = 3'd0,
        EV_BEGIN   = 3'd1,
        EV_STAY    = 3'd2,
        EV_RELEASE = 3'd3,
        EV_END     = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic load;        // capture the request
        logic scan_start;  // read slot 0
        logic scan_step;   // read the next slot
        logic write_hit;   // update the matched slot and report
        logic write_new;   // insert at the fill point and report
        logic emit_full;   // report table full
        logic emit_none;   // report disabled pair
    } cmd_t;

    typedef struct packed {
        logic layer_ok;    // layer pair in range and enabled
        logic fill_zero;   // no slot in use
        logic key_match;   // slot under compare holds the key
        logic scan_last;   // slot under compare is the last one in use
        logic full;        // every slot in use
    } status_t;

endpackage

>>> design/apct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apct_ctrl
// Sequencer for the tracker: accepts a request, checks the layer pair,
// walks the slots in use one per cycle and picks the commit action.
// ----------------------------------------------------------------------------
module apct_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  apct_pkg::status_t status,
    output apct_pkg::cmd_t    cmd,
    output logic             busy
);
    import apct_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                priority if (!status.layer_ok)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (status.fill_zero)
                begin
                    cmd.write_new = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                priority if (status.key_match)
                begin
                    cmd.write_hit = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (status.scan_last)
                begin
                    // key not stored: insert or give up
                    if (status.full)
                    begin
                        cmd.emit_full = 1'b1;
                    end
                    else
                    begin
                        cmd.write_new = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/apct_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apct_datapath
// Request registers, layer matrix, overlap test, pair slot memory with fill
// count, contact event logic and the result registers.
// ----------------------------------------------------------------------------
module apct_datapath #(
    parameter int LAYER_COUNT = 8,
    parameter int PAIR_SLOTS  = 64,
    parameter int ID_BITS     = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  apct_pkg::cmd_t            cmd,
    output apct_pkg::status_t         status,
    input  logic                      cfg_wr,
    input  logic [apct_pkg::CFG_DW-1:0] cfg_wdata,
    output logic [apct_pkg::CFG_DW-1:0] layer_enable,
    input  logic [2:0]                left_layer,
    input  logic [2:0]                right_layer,
    input  logic [31:0]               pair_key,
    input  logic signed [15:0]        left_x,
    input  logic signed [15:0]        left_y,
    input  logic [15:0]               left_w,
    input  logic [15:0]               left_h,
    input  logic signed [15:0]        right_x,
    input  logic signed [15:0]        right_y,
    input  logic [15:0]               right_w,
    input  logic [15:0]               right_h,
    input  logic                      any_dead,
    output logic                      done,
    output logic [apct_pkg::EVENT_W-1:0] event_res,
    output logic                      table_full
);
    import apct_pkg::*;

    localparam int KEY_HALF = (ID_BITS >= 16) ? 16 : ID_BITS;
    localparam int KEY_W    = 2 * KEY_HALF;
    localparam int IDX_W    = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
    localparam int FILL_W   = $clog2(PAIR_SLOTS + 1);

    // ---------------- configuration ----------------
    logic [CFG_DW-1:0] layer_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_enable_reg <= '0;
        end
        else if (cfg_wr)
        begin
            layer_enable_reg <= cfg_wdata;
        end
    end

    assign layer_enable = layer_enable_reg;

    // ---------------- request registers ----------------
    logic [2:0]        la_reg;
    logic [2:0]        lb_reg;
    logic [KEY_W-1:0]  key_reg;
    logic signed [15:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic [15:0]       lw_reg, lh_reg, rw_reg, rh_reg;
    logic              dead_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            la_reg   <= left_layer;
            lb_reg   <= right_layer;
            key_reg  <= {pair_key[16 +: KEY_HALF], pair_key[0 +: KEY_HALF]};
            lx_reg   <= left_x;
            ly_reg   <= left_y;
            lw_reg   <= left_w;
            lh_reg   <= left_h;
            rx_reg   <= right_x;
            ry_reg   <= right_y;
            rw_reg   <= right_w;
            rh_reg   <= right_h;
            dead_reg <= any_dead;
        end
    end

    // ---------------- layer matrix ----------------
    logic [2:0] row;
    logic [2:0] col;
    logic       layer_ok;

    always_comb
    begin
        if (la_reg <= lb_reg)
        begin
            row = la_reg;
            col = lb_reg;
        end
        else
        begin
            row = lb_reg;
            col = la_reg;
        end
        layer_ok = ({1'b0, la_reg} < 4'(LAYER_COUNT))
                && ({1'b0, lb_reg} < 4'(LAYER_COUNT))
                && layer_enable_reg[{row, col}];
    end

    // ---------------- overlap test: 2|d| < s1 + s2 per axis ----------------
    logic signed [16:0] dx, dy;
    logic [16:0]        adx, ady;
    logic [16:0]        sum_w, sum_h;
    logic               hit;

    always_comb
    begin
        dx    = 17'(lx_reg) - 17'(rx_reg);
        dy    = 17'(ly_reg) - 17'(ry_reg);
        adx   = dx[16] ? 17'(-dx) : 17'(dx);
        ady   = dy[16] ? 17'(-dy) : 17'(dy);
        sum_w = 17'(lw_reg) + 17'(rw_reg);
        sum_h = 17'(lh_reg) + 17'(rh_reg);
        hit   = ({adx, 1'b0} < {1'b0, sum_w}) && ({ady, 1'b0} < {1'b0, sum_h});
    end

    // ---------------- pair slot memory ----------------
    // Slots fill from the bottom and are never freed, so a slot is in use
    // exactly when its index is below the fill count.
    logic [KEY_W:0]    slot_mem [PAIR_SLOTS];
    logic [KEY_W:0]    rdata_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  slot_idx_reg;
    logic [IDX_W-1:0]  slot_idx_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [KEY_W:0]    wr_data;
    logic              contact_old;
    logic              contact_new;
    event_t            ev;

    always_comb
    begin
        slot_idx_next = slot_idx_reg;
        rd_addr       = slot_idx_reg;
        if (cmd.scan_start)
        begin
            slot_idx_next = '0;
            rd_addr       = '0;
        end
        else if (cmd.scan_step)
        begin
            slot_idx_next = slot_idx_reg + IDX_W'(1);
            rd_addr       = slot_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start || cmd.scan_step)
        begin
            rdata_reg <= slot_mem[rd_addr];
        end
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_idx_reg <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            slot_idx_reg <= slot_idx_next;
            fill_reg     <= fill_next;
        end
    end

    // ---------------- contact event ----------------
    always_comb
    begin
        contact_old = cmd.write_hit ? rdata_reg[KEY_W] : 1'b0;
        contact_new = contact_old;
        ev          = EV_NONE;
        if (hit)
        begin
            priority if (!contact_old)
            begin
                ev          = EV_BEGIN;
                contact_new = 1'b1;
            end
            else if (dead_reg)
            begin
                ev          = EV_RELEASE;
                contact_new = 1'b0;
            end
            else
            begin
                ev = EV_STAY;
            end
        end
        else if (contact_old)
        begin
            ev          = EV_END;
            contact_new = 1'b0;
        end

        wr_en     = cmd.write_hit || cmd.write_new;
        wr_addr   = cmd.write_hit ? slot_idx_reg : fill_reg[IDX_W-1:0];
        wr_data   = {contact_new, key_reg};
        fill_next = cmd.write_new ? fill_reg + FILL_W'(1) : fill_reg;
    end

    // ---------------- status ----------------
    always_comb
    begin
        status.layer_ok  = layer_ok;
        status.fill_zero = (fill_reg == '0);
        status.key_match = (rdata_reg[KEY_W-1:0] == key_reg);
        status.scan_last = ((FILL_W'(slot_idx_reg) + FILL_W'(1)) == fill_reg);
        status.full      = (fill_reg == FILL_W'(PAIR_SLOTS));
    end

    // ---------------- result registers ----------------
    logic              done_reg;
    logic [EVENT_W-1:0] event_res_reg;
    logic              table_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.write_hit || cmd.write_new || cmd.emit_full
                     || cmd.emit_none;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_hit || cmd.write_new)
        begin
            event_res_reg  <= ev;
            table_full_reg <= 1'b0;
        end
        else if (cmd.emit_full || cmd.emit_none)
        begin
            event_res_reg  <= EV_NONE;
            table_full_reg <= cmd.emit_full;
        end
    end

    assign done       = done_reg;
    assign event_res  = event_res_reg;
    assign table_full = table_full_reg;

endmodule

>>> design/aabb_pair_contact_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_pair_contact_tracker
// Axis-aligned box overlap test on one collider pair, tracked per pair key
// into begin / stay / release / end contact events.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result appears
// on event_res and table_full for exactly one cycle with done high; there is
// no back-pressure, so the receiver must take it in that cycle. busy is high
// through a check state after the request; it drops after that state when
// the layer pair is disabled or the pair table is empty, and otherwise stays
// high through the key search as well, which walks the slots one slot per
// cycle through the single read port of the slot memory, at most the number
// of slots in use and PAIR_SLOTS at most. done is high in the first cycle
// that busy is low again, and a new request may be taken in that same
// cycle. Slots are never freed; a new key takes the slot at the fill count,
// so no clearing pass is needed after reset. layer_enable sits at byte address
// 0 of the 64-bit register port and may only be written while busy is low.
// ----------------------------------------------------------------------------
module aabb_pair_contact_tracker #(
    parameter int LAYER_COUNT = 8,
    parameter int PAIR_SLOTS  = 64,
    parameter int ID_BITS     = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [apct_pkg::CFG_AW-1:0]  paddr,
    input  logic [apct_pkg::CFG_DW-1:0]  pwdata,
    output logic [apct_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready,
    // request
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   left_layer,
    input  logic [2:0]                   right_layer,
    input  logic [31:0]                  pair_key,
    input  logic signed [15:0]           left_x,
    input  logic signed [15:0]           left_y,
    input  logic [15:0]                  left_w,
    input  logic [15:0]                  left_h,
    input  logic signed [15:0]           right_x,
    input  logic signed [15:0]           right_y,
    input  logic [15:0]                  right_w,
    input  logic [15:0]                  right_h,
    input  logic                         any_dead,
    // result
    output logic                         done,
    output logic [apct_pkg::EVENT_W-1:0] event_res,
    output logic                         table_full
);
    import apct_pkg::*;

    cmd_t              cmd;
    status_t           status;
    logic              cfg_wr;
    logic [CFG_DW-1:0] layer_enable;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_LAYER_ENABLE);
    assign prdata = (paddr == ADDR_LAYER_ENABLE) ? layer_enable : '0;

    apct_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    apct_datapath #(
        .LAYER_COUNT (LAYER_COUNT),
        .PAIR_SLOTS  (PAIR_SLOTS),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr       (cfg_wr),
        .cfg_wdata    (pwdata),
        .layer_enable (layer_enable),
        .left_layer   (left_layer),
        .right_layer  (right_layer),
        .pair_key     (pair_key),
        .left_x       (left_x),
        .left_y       (left_y),
        .left_w       (left_w),
        .left_h       (left_h),
        .right_x      (right_x),
        .right_y      (right_y),
        .right_w      (right_w),
        .right_h      (right_h),
        .any_dead     (any_dead),
        .done         (done),
        .event_res    (event_res),
        .table_full   (table_full)
    );

endmodule
